@@ design/mef_pkg.sv @@
// shared types and constants for the median-then-ema position filter
// no dependencies; imported by every module of the filter
package mef_pkg;

    localparam int MAX_WINDOW_DEF = 16;
    localparam int MIN_MEDIAN     = 3;

    localparam logic [16:0] ALPHA_ONE = 17'h10000;

    typedef enum logic [1:0] {
        REG_MEDIAN_WINDOW = 2'd0,
        REG_EMA_ALPHA     = 2'd1,
        REG_AGE_LIMIT     = 2'd2
    } t_reg;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic        [31:0] time_ms;
    } t_pos_in;

    typedef struct packed {
        logic signed [31:0] filt_x;
        logic signed [31:0] filt_y;
        logic signed [31:0] filt_z;
    } t_pos_out;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } t_axes;

    typedef struct packed {
        logic load;
        logic rank_en;
    } t_cell_ctrl;

endpackage

@@ design/mef_cell.sv @@
// one window cell: holds a sample, shifts it to the older neighbor, and
// counts its per-axis rank against the broadcast sample. depends on mef_pkg
module mef_cell #(
    parameter int MAX_WINDOW = 16,
    parameter int IDX        = 0
) (
    input  logic                              i_clk,
    input  mef_pkg::t_cell_ctrl               i_ctrl,
    input  mef_pkg::t_pos_in                  i_prev,
    input  mef_pkg::t_pos_in                  i_bcast,
    input  logic [$clog2(MAX_WINDOW)-1:0]     i_t,
    input  logic [$clog2(MAX_WINDOW+1)-1:0]   i_k,
    input  logic [$clog2(MAX_WINDOW)-1:0]     i_mid,
    output mef_pkg::t_pos_in                  o_data,
    output mef_pkg::t_axes                    o_pick
);
    import mef_pkg::*;

    localparam int RW = $clog2(MAX_WINDOW);
    localparam int KW = $clog2(MAX_WINDOW + 1);

    t_pos_in          r_data;
    logic [RW-1:0]    r_rank_x;
    logic [RW-1:0]    r_rank_y;
    logic [RW-1:0]    r_rank_z;
    logic             w_earlier;
    logic             w_in_k;

    // ties are broken by position so the ranks form a permutation
    assign w_earlier = (i_t < RW'(IDX));
    assign w_in_k    = (KW'(IDX) < i_k);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_data   <= i_prev;
            r_rank_x <= '0;
            r_rank_y <= '0;
            r_rank_z <= '0;
        end else if (i_ctrl.rank_en) begin
            if ((i_bcast.pos_x < r_data.pos_x) ||
                (i_bcast.pos_x == r_data.pos_x && w_earlier)) begin
                r_rank_x <= r_rank_x + 1'b1;
            end
            if ((i_bcast.pos_y < r_data.pos_y) ||
                (i_bcast.pos_y == r_data.pos_y && w_earlier)) begin
                r_rank_y <= r_rank_y + 1'b1;
            end
            if ((i_bcast.pos_z < r_data.pos_z) ||
                (i_bcast.pos_z == r_data.pos_z && w_earlier)) begin
                r_rank_z <= r_rank_z + 1'b1;
            end
        end
    end

    assign o_data   = r_data;
    assign o_pick.x = (w_in_k && r_rank_x == i_mid) ? r_data.pos_x : '0;
    assign o_pick.y = (w_in_k && r_rank_y == i_mid) ? r_data.pos_y : '0;
    assign o_pick.z = (w_in_k && r_rank_z == i_mid) ? r_data.pos_z : '0;

endmodule

@@ design/mef_ema.sv @@
// exponential moving average of the three median values, q16 weight
// depends on mef_pkg; seeds on the first median after reset
module mef_ema (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  mef_pkg::t_axes  i_med,
    input  logic [16:0]     i_alpha,
    output logic            o_done,
    output mef_pkg::t_axes  o_smooth
);
    import mef_pkg::*;

    t_axes          r_smooth;
    logic           r_seeded;
    logic           r_mul;
    logic           r_done;
    logic [50:0]    r_prod_x;
    logic [50:0]    r_prod_y;
    logic [50:0]    r_prod_z;
    logic [16:0]    w_alpha;

    // s = prev + alpha*(m - prev), rounded half up
    function automatic logic [50:0] ema_mul(input logic [16:0] a,
                                            input logic signed [31:0] m,
                                            input logic signed [31:0] prev);
        logic signed [32:0] d;
        d = {m[31], m} - {prev[31], prev};
        return $signed({1'b0, a}) * d;
    endfunction

    function automatic logic [31:0] ema_fin(input logic signed [31:0] prev,
                                            input logic [50:0] prod);
        logic [51:0] sum;
        sum = {{4{prev[31]}}, prev, 16'h0000} + {prod[50], prod} + 52'd32768;
        return sum[47:16];
    endfunction

    assign w_alpha = (i_alpha > ALPHA_ONE) ? ALPHA_ONE : i_alpha;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smooth <= '0;
            r_seeded <= 1'b0;
            r_mul    <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_done <= 1'b0;
            r_mul  <= 1'b0;
            if (i_start) begin
                if (!r_seeded) begin
                    r_smooth <= i_med;
                    r_seeded <= 1'b1;
                    r_done   <= 1'b1;
                end else begin
                    r_mul <= 1'b1;
                end
            end
            if (r_mul) begin
                r_smooth.x <= ema_fin(r_smooth.x, r_prod_x);
                r_smooth.y <= ema_fin(r_smooth.y, r_prod_y);
                r_smooth.z <= ema_fin(r_smooth.z, r_prod_z);
                r_done     <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_prod_x <= ema_mul(w_alpha, i_med.x, r_smooth.x);
            r_prod_y <= ema_mul(w_alpha, i_med.y, r_smooth.y);
            r_prod_z <= ema_mul(w_alpha, i_med.z, r_smooth.z);
        end
    end

    assign o_done   = r_done;
    assign o_smooth = r_smooth;

endmodule

@@ design/median_ema_position_filter.sv @@
// each request runs an age check that drops D aged samples (0..fill-1), then a rank pass over the
// cell chain for the median length k (up to MAX_WINDOW), a median select and the average
// throughput: one request at a time (D + k <= fill)
// a finished result waits in the output register while the next request is taken
// reset (synchronous, active low) empties the window, unseeds the average and loads
// the register defaults: median_window 7, ema_alpha 32768, age_limit_ms 2000
module median_ema_position_filter #(
    parameter int MAX_WINDOW = mef_pkg::MAX_WINDOW_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  mef_pkg::t_pos_in    i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output mef_pkg::t_pos_out   o_out_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import mef_pkg::*;

    localparam int RW = $clog2(MAX_WINDOW);
    localparam int KW = $clog2(MAX_WINDOW + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DROP = 3'd1;
    localparam logic [2:0] S_RANK = 3'd2;
    localparam logic [2:0] S_SEL  = 3'd3;
    localparam logic [2:0] S_EMA  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]     r_state;
    logic [2:0]     n_state;
    logic [4:0]     r_median_window;
    logic [16:0]    r_ema_alpha;
    logic [15:0]    r_age_limit;
    logic [KW-1:0]  r_fill;
    logic [KW-1:0]  r_k;
    logic [RW-1:0]  r_t;
    logic [31:0]    r_now;
    t_axes          r_med;
    logic           r_start;
    logic           r_out_valid;
    t_pos_out       r_out;

    t_pos_in        w_cell [MAX_WINDOW];
    t_axes          w_pick [MAX_WINDOW];
    t_pos_in        w_bcast;
    t_axes          w_med;
    t_axes          w_smooth;
    t_cell_ctrl     w_ctrl;
    logic           w_in_acc;
    logic           w_cfg_wr;
    logic           w_too_old;
    logic           w_out_load;
    logic           w_ema_done;
    logic [RW-1:0]  w_rd_idx;
    logic [RW-1:0]  w_mid;
    logic [KW-1:0]  w_fill_m1;
    logic [KW-1:0]  w_k_m1;
    logic [KW-1:0]  w_win;
    logic [31:0]    w_age;

    // configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_median_window <= 5'd7;
            r_ema_alpha     <= 17'd32768;
            r_age_limit     <= 16'd2000;
        end else if (w_cfg_wr) begin
            case (paddr[3:2])
                REG_MEDIAN_WINDOW: r_median_window <= pwdata[4:0];
                REG_EMA_ALPHA:     r_ema_alpha     <= pwdata[16:0];
                REG_AGE_LIMIT:     r_age_limit     <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_MEDIAN_WINDOW: prdata = {27'd0, r_median_window};
            REG_EMA_ALPHA:     prdata = {15'd0, r_ema_alpha};
            REG_AGE_LIMIT:     prdata = {16'd0, r_age_limit};
            default:           prdata = '0;
        endcase
    end

    // effective median length, clamped to [3, MAX_WINDOW]
    always_comb begin
        if (int'(r_median_window) > MAX_WINDOW) begin
            w_win = KW'(MAX_WINDOW);
        end else if (int'(r_median_window) < MIN_MEDIAN) begin
            w_win = KW'(MIN_MEDIAN);
        end else begin
            w_win = KW'(r_median_window);
        end
    end

    assign w_in_acc   = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign w_fill_m1  = r_fill - 1'b1;
    assign w_k_m1     = r_k - 1'b1;
    assign w_mid      = RW'(r_k >> 1);
    assign w_rd_idx   = (r_state == S_DROP) ? w_fill_m1[RW-1:0] : r_t;
    assign w_bcast    = w_cell[w_rd_idx];
    assign w_age      = r_now - w_bcast.time_ms;
    assign w_too_old  = (r_fill > KW'(1)) && (w_age > {16'd0, r_age_limit});
    assign w_out_load = (r_state == S_OUT) && (!r_out_valid || i_out_ready);

    assign w_ctrl.load    = w_in_acc;
    assign w_ctrl.rank_en = (r_state == S_RANK);

    // window chain: cell 0 holds the newest sample
    for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
        mef_cell #(
            .MAX_WINDOW (MAX_WINDOW),
            .IDX        (i)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl),
            .i_prev  ((i == 0) ? i_in_data : w_cell[(i == 0) ? 0 : i - 1]),
            .i_bcast (w_bcast),
            .i_t     (r_t),
            .i_k     (r_k),
            .i_mid   (w_mid),
            .o_data  (w_cell[i]),
            .o_pick  (w_pick[i])
        );
    end

    // exactly one cell per axis holds the middle rank
    always_comb begin
        w_med = '0;
        for (int i = 0; i < MAX_WINDOW; i++) begin
            w_med = w_med | w_pick[i];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (w_in_acc) n_state = S_DROP;
            S_DROP: if (!w_too_old) n_state = S_RANK;
            S_RANK: if (KW'(r_t) == w_k_m1) n_state = S_SEL;
            S_SEL:  n_state = S_EMA;
            S_EMA:  if (w_ema_done) n_state = S_OUT;
            S_OUT:  if (w_out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_k         <= '0;
            r_t         <= '0;
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_start <= (r_state == S_SEL);
            if (w_in_acc && r_fill != KW'(MAX_WINDOW)) begin
                r_fill <= r_fill + 1'b1;
            end
            if (r_state == S_DROP) begin
                if (w_too_old) begin
                    r_fill <= w_fill_m1;
                end else begin
                    r_k <= (r_fill < w_win) ? r_fill : w_win;
                    r_t <= '0;
                end
            end
            if (r_state == S_RANK) begin
                r_t <= r_t + 1'b1;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_now <= i_in_data.time_ms;
        end
        if (r_state == S_SEL) begin
            r_med <= w_med;
        end
        if (w_out_load) begin
            r_out.filt_x <= w_smooth.x;
            r_out.filt_y <= w_smooth.y;
            r_out.filt_z <= w_smooth.z;
        end
    end

    mef_ema u_ema (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_start),
        .i_med    (r_med),
        .i_alpha  (r_ema_alpha),
        .o_done   (w_ema_done),
        .o_smooth (w_smooth)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_fill) <= MAX_WINDOW)
        else $error("window fill count beyond store depth");

    a_fill_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_fill != '0))
        else $error("request in flight with an empty window");

    a_accept_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == S_DROP))
        else $error("accepted request did not start the age check");

    a_ema_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ema_done |-> (r_state == S_EMA))
        else $error("average finished outside its wait state");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |=> (o_out_valid && r_state == S_IDLE))
        else $error("result not presented after output load");

endmodule

@@ tb/tb_median_ema_position_filter.sv @@
`timescale 1ns / 1ps
// testbench for median_ema_position_filter: directed and random timestamped position requests
// under several apb register settings, checked against a scoreboard that predicts each result
// depends on mef_pkg and the filter rtl
module tb_median_ema_position_filter;
    import mef_pkg::*;

    localparam int DEPTH         = MAX_WINDOW_DEF;
    localparam int SETTLE_CYCLES = 2 * DEPTH + 16;
    localparam int REPORT_LIMIT  = 10;

    class filter_scoreboard;
        int          store_x[DEPTH];
        int          store_y[DEPTH];
        int          store_z[DEPTH];
        logic [31:0] store_time[DEPTH];
        int unsigned fill;
        int unsigned slot;
        int          avg_x;
        int          avg_y;
        int          avg_z;
        bit          seeded;
        logic [4:0]  median_window;
        logic [16:0] ema_alpha;
        logic [15:0] age_limit_ms;
        t_pos_out    expected_q[$];
        int          mismatches;

        function new();
            fill          = 0;
            slot          = 0;
            avg_x         = 0;
            avg_y         = 0;
            avg_z         = 0;
            seeded        = 0;
            median_window = 5'd7;
            ema_alpha     = 17'd32768;
            age_limit_ms  = 16'd2000;
            mismatches    = 0;
        endfunction

        function void set_reg(t_reg idx, logic [31:0] value);
            case (idx)
                REG_MEDIAN_WINDOW: median_window = value[4:0];
                REG_EMA_ALPHA:     ema_alpha     = value[16:0];
                REG_AGE_LIMIT:     age_limit_ms  = value[15:0];
                default: ;
            endcase
        endfunction

        // slot holding the i-th newest sample
        function int unsigned back_slot(int unsigned i);
            return (slot + 2 * DEPTH - 1 - i) % DEPTH;
        endfunction

        function int median_of(int vals[DEPTH], int unsigned k);
            int v[DEPTH];
            int x;
            int j;
            for (int i = 0; i < k; i++) v[i] = vals[back_slot(i)];
            for (int i = 1; i < k; i++) begin
                x = v[i];
                j = i;
                while (j > 0 && v[j - 1] > x) begin
                    v[j] = v[j - 1];
                    j--;
                end
                v[j] = x;
            end
            return v[k / 2];
        endfunction

        // round half up, arithmetic shift
        function int smooth_step(int m, int prev, int a);
            longint sum;
            sum = longint'(a) * m + longint'(65536 - a) * prev + 64'sd32768;
            return int'(sum >>> 16);
        endfunction

        function void note_request(t_pos_in req);
            int unsigned w;
            int unsigned k;
            logic [31:0] age;
            bit          aging;
            int          a;
            t_pos_out    res;
            store_x[slot]    = req.pos_x;
            store_y[slot]    = req.pos_y;
            store_z[slot]    = req.pos_z;
            store_time[slot] = req.time_ms;
            slot = (slot + 1) % DEPTH;
            if (fill < DEPTH) fill++;
            // stale samples leave from the oldest end only
            aging = 1;
            while (aging && fill > 1) begin
                age = req.time_ms - store_time[back_slot(fill - 1)];
                if (age > {16'd0, age_limit_ms}) fill--;
                else aging = 0;
            end
            w = median_window;
            if (w > DEPTH) w = DEPTH;
            if (w < MIN_MEDIAN) w = MIN_MEDIAN;
            k = (fill < w) ? fill : w;
            if (!seeded) begin
                avg_x  = median_of(store_x, k);
                avg_y  = median_of(store_y, k);
                avg_z  = median_of(store_z, k);
                seeded = 1;
            end else begin
                a = (ema_alpha > ALPHA_ONE) ? int'(ALPHA_ONE) : int'(ema_alpha);
                avg_x = smooth_step(median_of(store_x, k), avg_x, a);
                avg_y = smooth_step(median_of(store_y, k), avg_y, a);
                avg_z = smooth_step(median_of(store_z, k), avg_z, a);
            end
            res.filt_x = avg_x;
            res.filt_y = avg_y;
            res.filt_z = avg_z;
            expected_q.insert(expected_q.size(), res);
        endfunction

        function void check_result(t_pos_out got);
            t_pos_out want;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("result with no request pending: x=%0d y=%0d z=%0d",
                             got.filt_x, got.filt_y, got.filt_z);
                return;
            end
            want = expected_q[0];
            expected_q.delete(0);
            if (got.filt_x !== want.filt_x || got.filt_y !== want.filt_y ||
                    got.filt_z !== want.filt_z) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("mismatch: expected x=%0d y=%0d z=%0d, got x=%0d y=%0d z=%0d",
                             want.filt_x, want.filt_y, want.filt_z,
                             got.filt_x, got.filt_y, got.filt_z);
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_pos_in     i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_pos_out    o_out_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    filter_scoreboard sb = new();
    bit          steady_run = 1'b0;
    logic [31:0] sample_time;
    int          track_x;
    int          track_y;
    int          track_z;

    median_ema_position_filter uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        i_out_ready <= steady_run || ($urandom_range(99) >= 15);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_result(o_out_data);
    end

    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    // all driving tasks start and end at a falling edge
    task automatic apb_write(t_reg idx, logic [31:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_reg(idx, value);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic configure(logic [31:0] window, logic [31:0] alpha, logic [31:0] age);
        apb_write(REG_MEDIAN_WINDOW, window);
        apb_write(REG_EMA_ALPHA, alpha);
        apb_write(REG_AGE_LIMIT, age);
    endtask

    task automatic send_request(t_pos_in req);
        while (!steady_run && $urandom_range(99) < 15) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_data  = req;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_request(req);
        @(negedge i_clk);
    endtask

    task automatic send_xyz(int x, int y, int z, logic [31:0] t);
        t_pos_in req;
        req.pos_x   = x;
        req.pos_y   = y;
        req.pos_z   = z;
        req.time_ms = t;
        send_request(req);
    endtask

    task automatic wait_drained(int settle);
        i_in_valid = 1'b0;
        while (sb.expected_q.size() != 0) @(negedge i_clk);
        repeat (settle) @(negedge i_clk);
    endtask

    // mostly a noisy track, with spikes and extremes mixed in
    function automatic int axis_value(int track);
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 70) return track + int'($urandom_range(8191)) - 4096;
        if (pick < 88) return int'($urandom);
        case ($urandom_range(3))
            0: return 32'sh8000_0000;
            1: return 32'sh7FFF_FFFF;
            2: return 0;
            default: return -1;
        endcase
    endfunction

    function automatic t_pos_in next_sample(int unsigned step_div);
        int unsigned pick;
        int unsigned lim;
        t_pos_in     req;
        lim  = sb.age_limit_ms;
        pick = $urandom_range(99);
        if (pick < 4) sample_time = $urandom;
        else if (pick < 10) sample_time += lim + $urandom_range(1, 3000);
        else sample_time += $urandom_range(0, lim / step_div + 1);
        track_x += int'($urandom_range(65535)) - 32768;
        track_y += int'($urandom_range(65535)) - 32768;
        track_z += int'($urandom_range(65535)) - 32768;
        req.pos_x   = axis_value(track_x);
        req.pos_y   = axis_value(track_y);
        req.pos_z   = axis_value(track_z);
        req.time_ms = sample_time;
        return req;
    endfunction

    task automatic run_phase(int n_items, int unsigned step_div, bit hold_mid);
        for (int i = 0; i < n_items; i++) begin
            if (hold_mid && i == n_items / 2) wait_drained(0);
            send_request(next_sample(step_div));
        end
        wait_drained(SETTLE_CYCLES);
    endtask

    initial begin
        logic [31:0] alpha;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // reset defaults: seeding, extremes, rounding halves, age boundary and wrap
        send_xyz(32'sh7FFF_FFFF, 32'sh8000_0000, 0, 32'd0);
        send_xyz(32'sh8000_0000, 32'sh7FFF_FFFF, -1, 32'd1);
        send_xyz(-1, 1, 32'sh7FFF_FFFF, 32'd2);
        send_xyz(1, -1, 32'sh8000_0000, 32'd3);
        send_xyz(3, -3, 1, 32'd3);
        send_xyz(0, 0, 0, 32'd2003);
        send_xyz(5, -5, 7, 32'hFFFF_FFF0);
        send_xyz(6, -6, 8, 32'h0000_0005);
        send_xyz(7, -7, 9, 32'd6);
        wait_drained(SETTLE_CYCLES);

        // window below minimum, alpha above one, zero age limit
        configure(32'd2, 32'h1FFFF, 32'd0);
        send_xyz(100, -100, 1000, 32'd100);
        send_xyz(-50, 50, 2000, 32'd100);
        send_xyz(70, -70, -3000, 32'd100);
        send_xyz(10, -10, 4000, 32'd100);
        send_xyz(11, -11, 12, 32'd101);
        wait_drained(SETTLE_CYCLES);

        // window above depth, alpha zero holds the average, widest age limit
        configure(32'd31, 32'd0, 32'd65535);
        send_xyz(1, 2, 3, 32'd200);
        send_xyz(-4, 5, -6, 32'd201);
        send_xyz(7, -8, 9, 32'd202);
        send_xyz(32'sh7FFF_FFFF, 32'sh8000_0000, 0, 32'd203);
        send_xyz(2, 3, 4, 32'd65738);
        send_xyz(3, 4, 5, 32'd65740);
        wait_drained(SETTLE_CYCLES);

        sample_time = $urandom;
        track_x     = int'($urandom);
        track_y     = int'($urandom);
        track_z     = int'($urandom);

        // dense samples, mostly fresh, so the store fills and wraps, no idling on either side
        configure(32'd16, 32'd65536, 32'd65535);
        steady_run = 1'b1;
        run_phase(70, 256, 1'b0);
        steady_run = 1'b0;

        configure(32'd0, 32'd0, 32'd0);
        run_phase(50, 1, 1'b0);

        configure(32'd31, 32'h1FFFF, 32'd100);
        run_phase(50, 16, 1'b1);

        configure(32'd4, 32'd1, 32'd2000);
        run_phase(50, 8, 1'b0);

        for (int p = 0; p < 8; p++) begin
            alpha = ($urandom_range(3) == 0) ? $urandom_range(131071) : $urandom_range(65536);
            configure($urandom_range(31), alpha,
                      ($urandom_range(1) != 0) ? $urandom_range(65535) : $urandom_range(50));
            run_phase(50, $urandom_range(1, 64), 1'b0);
        end

        if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
